// ----- sv/complex_arithmetic_unit_macros.svh -----
// Assertion macros used by the queue of the complex arithmetic unit RTL
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// property that holds at every clock edge outside reset
`define CAU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property whose consequent holds in the cycle after its antecedent
`define CAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/cau_pkg.sv -----
// Types, constants and arithmetic helpers of the complex arithmetic unit
package cau_pkg;

   localparam int DW        = 32;
   localparam int FB        = 16;
   localparam int CS        = 16;
   localparam int PW        = 2 * DW;
   localparam int CORDIC_SH = 28;
   localparam int ANG_SH    = 60 - FB;

   localparam logic signed [63:0] PI4_Z = 64'sd905502432259640348;
   localparam logic signed [DW-1:0] HALF_PI_Q =
      DW'((2 * PI4_Z + (64'sd1 <<< (ANG_SH - 1))) >>> ANG_SH);

   localparam logic [63:0] ONE_S60 = 64'd1 << 60;
   localparam logic [30:0][63:0] INV_ODD = {
      ONE_S60 / 64'd61, ONE_S60 / 64'd59, ONE_S60 / 64'd57, ONE_S60 / 64'd55,
      ONE_S60 / 64'd53, ONE_S60 / 64'd51, ONE_S60 / 64'd49, ONE_S60 / 64'd47,
      ONE_S60 / 64'd45, ONE_S60 / 64'd43, ONE_S60 / 64'd41, ONE_S60 / 64'd39,
      ONE_S60 / 64'd37, ONE_S60 / 64'd35, ONE_S60 / 64'd33, ONE_S60 / 64'd31,
      ONE_S60 / 64'd29, ONE_S60 / 64'd27, ONE_S60 / 64'd25, ONE_S60 / 64'd23,
      ONE_S60 / 64'd21, ONE_S60 / 64'd19, ONE_S60 / 64'd17, ONE_S60 / 64'd15,
      ONE_S60 / 64'd13, ONE_S60 / 64'd11, ONE_S60 / 64'd9,  ONE_S60 / 64'd7,
      ONE_S60 / 64'd5,  ONE_S60 / 64'd3,  ONE_S60 / 64'd1
   };

   typedef enum logic [3:0] {
      CMD_ADD     = 4'd0,
      CMD_SUB     = 4'd1,
      CMD_MUL     = 4'd2,
      CMD_DIV     = 4'd3,
      CMD_SCALE   = 4'd4,
      CMD_DIVREAL = 4'd5,
      CMD_REALDIV = 4'd6,
      CMD_CONJ    = 4'd7,
      CMD_MOD     = 4'd8,
      CMD_ARG     = 4'd9
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_DZ  = 2'd1,
      ST_SAT = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CLS_DONE = 2'd0,
      CLS_DIV  = 2'd1,
      CLS_SQRT = 2'd2,
      CLS_ARG  = 2'd3
   } cls_type;

   typedef struct packed {
      logic [3:0]          command;
      logic signed [DW-1:0] a_re;
      logic signed [DW-1:0] a_im;
      logic signed [DW-1:0] b_re;
      logic signed [DW-1:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [DW-1:0] res_re;
      logic signed [DW-1:0] res_im;
      logic [1:0]           status;
   } rsp_type;

   typedef struct packed {
      cls_type              cls;
      rsp_type              done;
      logic                 neg_re;
      logic                 neg_im;
      logic [PW-1:0]        mag_re;
      logic [PW-1:0]        mag_im;
      logic [PW-1:0]        den;
      logic [PW-1:0]        sq_v;
      logic signed [PW-1:0] x;
      logic signed [PW-1:0] y;
   } work_type;

   function automatic logic [DW:0] sat_wide(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] max_w;
      logic signed [PW-1:0] min_w;
      max_w = $signed({{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}});
      min_w = $signed({{(PW-DW+1){1'b1}}, {(DW-1){1'b0}}});
      if (v > max_w) return {1'b1, max_w[DW-1:0]};
      if (v < min_w) return {1'b1, min_w[DW-1:0]};
      return {1'b0, v[DW-1:0]};
   endfunction

   function automatic logic [DW:0] sat_mag(input logic neg, input logic [DW-1:0] mag,
                                           input logic big);
      logic [DW-1:0] lim;
      logic [DW-1:0] minm;
      lim  = {1'b0, {(DW-1){1'b1}}};
      minm = {1'b1, {(DW-1){1'b0}}};
      if (!neg) begin
         if (big || mag > lim) return {1'b1, lim};
         return {1'b0, mag};
      end
      if (big || mag > minm) return {1'b1, minm};
      return {1'b0, DW'(~mag + 1'b1)};
   endfunction

   function automatic logic signed [63:0] atan_pow2(input int i);
      logic signed [63:0] sum;
      int e;
      sum = '0;
      if (i == 0) return PI4_Z;
      for (int k = 0; k < 31; k++) begin
         e = i * (2 * k + 1);
         if (e <= 60) begin
            if (k[0]) sum = sum - $signed(INV_ODD[k] >> e);
            else sum = sum + $signed(INV_ODD[k] >> e);
         end
      end
      return sum;
   endfunction

endpackage

// ----- sv/cau_queue.sv -----
// Small first-in first-out queue of words held in registers
`include "complex_arithmetic_unit_macros.svh"

module cau_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             push_ok, pop_ok;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push_ok) wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop_ok) rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (push_ok && !pop_ok) cnt_in = cnt_ff + 1'b1;
      else if (pop_ok && !push_ok) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) mem_ff[wr_ff] <= push_data;
   end

   `CAU_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= CW'(DEPTH), "queue count beyond depth")
   `CAU_ASSERT(a_no_push_full, clock, reset, !(push && full), "push into full queue")
   `CAU_ASSERT_NEXT(a_drain, clock, reset, pop_ok && !push_ok && cnt_ff == CW'(1), empty, "queue not empty after last pop")
   `CAU_ASSERT_NEXT(a_fill, clock, reset, push_ok && !pop_ok, !empty, "queue empty after push")

endmodule

// ----- sv/cau_front.sv -----
// Front end: operand products, operation classification and simple results
module cau_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  cau_pkg::req_type  req_data,
   output logic              req_full,
   output logic              wk_push,
   output cau_pkg::work_type wk_data,
   input  logic              wk_full
);
   import cau_pkg::*;

   logic                 en;
   logic                 f1_v_ff, f2_v_ff;
   req_type              f1_req_ff;
   logic signed [PW-1:0] pa_ff, pb_ff, pc_ff, pd_ff, pe_ff, pf_ff, pg_ff, ph_ff;
   logic signed [PW-1:0] pa_in, pb_in, pc_in, pd_in, pe_in, pf_in, pg_in, ph_in;
   work_type             wk_ff, wk_in;

   logic signed [DW:0]   s_re, s_im;
   logic signed [PW:0]   w_re, w_im, n_re, n_im;
   logic signed [PW:0]   sh_re, sh_im;
   logic [DW:0]          r_re, r_im;
   logic [PW-1:0]        den;
   logic                 den_neg;
   logic signed [PW-1:0] ar, ai, br, ax, ay;

   assign en       = !f2_v_ff || !wk_full;
   assign req_full = !en;
   assign wk_push  = f2_v_ff && !wk_full;
   assign wk_data  = wk_ff;

   assign pa_in = req_data.a_re * req_data.b_re;
   assign pb_in = req_data.a_im * req_data.b_im;
   assign pc_in = req_data.a_re * req_data.b_im;
   assign pd_in = req_data.a_im * req_data.b_re;
   assign pe_in = req_data.a_re * req_data.a_re;
   assign pf_in = req_data.a_im * req_data.a_im;
   assign pg_in = req_data.b_re * req_data.b_re;
   assign ph_in = req_data.b_im * req_data.b_im;

   always_comb begin
      ar      = PW'(f1_req_ff.a_re);
      ai      = PW'(f1_req_ff.a_im);
      br      = PW'(f1_req_ff.b_re);
      ax      = '0;
      ay      = '0;
      s_re    = '0;
      s_im    = '0;
      w_re    = '0;
      w_im    = '0;
      sh_re   = '0;
      sh_im   = '0;
      r_re    = '0;
      r_im    = '0;
      n_re    = '0;
      n_im    = '0;
      den     = '0;
      den_neg = 1'b0;
      wk_in   = '0;
      wk_in.cls = CLS_DONE;
      wk_in.done.status = ST_OK;
      unique case (cmd_type'(f1_req_ff.command))
         CMD_ADD, CMD_SUB: begin
            if (cmd_type'(f1_req_ff.command) == CMD_ADD) begin
               s_re = {f1_req_ff.a_re[DW-1], f1_req_ff.a_re} + {f1_req_ff.b_re[DW-1], f1_req_ff.b_re};
               s_im = {f1_req_ff.a_im[DW-1], f1_req_ff.a_im} + {f1_req_ff.b_im[DW-1], f1_req_ff.b_im};
            end else begin
               s_re = {f1_req_ff.a_re[DW-1], f1_req_ff.a_re} - {f1_req_ff.b_re[DW-1], f1_req_ff.b_re};
               s_im = {f1_req_ff.a_im[DW-1], f1_req_ff.a_im} - {f1_req_ff.b_im[DW-1], f1_req_ff.b_im};
            end
            r_re = sat_wide(PW'(s_re));
            r_im = sat_wide(PW'(s_im));
         end
         CMD_MUL, CMD_SCALE: begin
            if (cmd_type'(f1_req_ff.command) == CMD_MUL) begin
               w_re = {pa_ff[PW-1], pa_ff} - {pb_ff[PW-1], pb_ff};
               w_im = {pc_ff[PW-1], pc_ff} + {pd_ff[PW-1], pd_ff};
            end else begin
               w_re = {pa_ff[PW-1], pa_ff};
               w_im = {pd_ff[PW-1], pd_ff};
            end
            sh_re = w_re >>> FB;
            sh_im = w_im >>> FB;
            r_re  = sat_wide(sh_re[PW-1:0]);
            r_im  = sat_wide(sh_im[PW-1:0]);
         end
         CMD_DIV, CMD_REALDIV, CMD_DIVREAL: begin
            if (cmd_type'(f1_req_ff.command) == CMD_DIV) begin
               den  = pg_ff + ph_ff;
               n_re = {pa_ff[PW-1], pa_ff} + {pb_ff[PW-1], pb_ff};
               n_im = {pd_ff[PW-1], pd_ff} - {pc_ff[PW-1], pc_ff};
            end else if (cmd_type'(f1_req_ff.command) == CMD_REALDIV) begin
               den  = pe_ff + pf_ff;
               n_re = {pa_ff[PW-1], pa_ff};
               n_im = -{pd_ff[PW-1], pd_ff};
            end else begin
               den     = br[PW-1] ? PW'(-br) : br;
               den_neg = br[PW-1];
               n_re    = {ar[PW-1], ar};
               n_im    = {ai[PW-1], ai};
            end
            if (den == '0) begin
               wk_in.done.status = ST_DZ;
            end else begin
               wk_in.cls    = CLS_DIV;
               wk_in.den    = den;
               wk_in.neg_re = n_re[PW] ^ den_neg;
               wk_in.neg_im = n_im[PW] ^ den_neg;
               wk_in.mag_re = n_re[PW] ? PW'(-n_re) : n_re[PW-1:0];
               wk_in.mag_im = n_im[PW] ? PW'(-n_im) : n_im[PW-1:0];
            end
         end
         CMD_CONJ: begin
            r_re = {1'b0, f1_req_ff.a_re};
            r_im = sat_wide(-ai);
         end
         CMD_MOD: begin
            wk_in.cls  = CLS_SQRT;
            wk_in.sq_v = pe_ff + pf_ff;
         end
         CMD_ARG: begin
            if (ar == '0) begin
               wk_in.done.status = ST_DZ;
               r_re = {1'b0, (ai < 0) ? -HALF_PI_Q : HALF_PI_Q};
            end else begin
               ax = (ar < 0) ? -ar : ar;
               ay = (ar < 0) ? -ai : ai;
               wk_in.cls = CLS_ARG;
               wk_in.x   = ax <<< CORDIC_SH;
               wk_in.y   = ay <<< CORDIC_SH;
            end
         end
         default: begin
         end
      endcase
      wk_in.done.res_re = r_re[DW-1:0];
      wk_in.done.res_im = r_im[DW-1:0];
      if (wk_in.done.status == ST_OK && (r_re[DW] || r_im[DW])) wk_in.done.status = ST_SAT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
      end else if (en) begin
         f1_v_ff <= req_push;
         f2_v_ff <= f1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_req_ff <= req_data;
         pa_ff     <= pa_in;
         pb_ff     <= pb_in;
         pc_ff     <= pc_in;
         pd_ff     <= pd_in;
         pe_ff     <= pe_in;
         pf_ff     <= pf_in;
         pg_ff     <= pg_in;
         ph_ff     <= ph_in;
         wk_ff     <= wk_in;
      end
   end

endmodule

// ----- sv/cau_back.sv -----
// Back end: pipelined divider, square root and vectoring rotator
module cau_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              wk_empty,
   input  cau_pkg::work_type wk_data,
   output logic              wk_pop,
   output logic              out_push,
   output cau_pkg::rsp_type  out_data,
   input  logic              out_full
);
   import cau_pkg::*;

   typedef struct packed {
      cls_type              cls;
      rsp_type              done;
      logic                 neg_re;
      logic                 neg_im;
      logic                 big_re;
      logic                 big_im;
      logic [PW-1:0]        den;
      logic [PW-1:0]        r_re;
      logic [PW-1:0]        r_im;
      logic [DW-1:0]        lo_re;
      logic [DW-1:0]        lo_im;
      logic [DW-1:0]        q_re;
      logic [DW-1:0]        q_im;
      logic [PW-1:0]        sq_v;
      logic [PW-1:0]        sq_r;
      logic signed [PW-1:0] x;
      logic signed [PW-1:0] y;
      logic signed [PW-1:0] z;
   } stg_type;

   logic          en;
   logic          v_ff [DW+1];
   stg_type       st_ff [DW+1];
   stg_type       st0_in;
   logic [PW-1:0] hi_re, hi_im;
   logic          tail_v_ff;
   rsp_type       tail_ff, tail_in;
   logic [DW:0]   f_re, f_im;
   logic signed [PW-1:0] za;

   assign en       = !tail_v_ff || !out_full;
   assign wk_pop   = !wk_empty && en;
   assign out_push = tail_v_ff && !out_full;
   assign out_data = tail_ff;

   always_comb begin
      hi_re         = wk_data.mag_re >> (DW - FB);
      hi_im         = wk_data.mag_im >> (DW - FB);
      st0_in        = '0;
      st0_in.cls    = wk_data.cls;
      st0_in.done   = wk_data.done;
      st0_in.neg_re = wk_data.neg_re;
      st0_in.neg_im = wk_data.neg_im;
      st0_in.den    = wk_data.den;
      st0_in.big_re = hi_re >= wk_data.den;
      st0_in.big_im = hi_im >= wk_data.den;
      st0_in.r_re   = hi_re;
      st0_in.r_im   = hi_im;
      st0_in.lo_re  = {wk_data.mag_re[DW-FB-1:0], FB'(0)};
      st0_in.lo_im  = {wk_data.mag_im[DW-FB-1:0], FB'(0)};
      st0_in.sq_v   = wk_data.sq_v;
      st0_in.x      = wk_data.x;
      st0_in.y      = wk_data.y;
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else if (en) v_ff[0] <= !wk_empty;
   end

   always_ff @(posedge clock) begin
      if (en) st_ff[0] <= st0_in;
   end

   for (genvar s = 1; s <= DW; s++) begin : g_stage
      localparam logic [PW-1:0] SQ_BIT = PW'(1) << (2 * (DW - s));
      localparam logic signed [63:0] AT = atan_pow2(s - 1);
      stg_type              nx;
      logic [PW:0]          tr_re, tr_im;
      logic [PW-1:0]        sq_t;
      logic signed [PW-1:0] xs, ys;

      always_comb begin
         nx    = st_ff[s-1];
         tr_re = {st_ff[s-1].r_re, st_ff[s-1].lo_re[DW-1]};
         tr_im = {st_ff[s-1].r_im, st_ff[s-1].lo_im[DW-1]};
         nx.lo_re = st_ff[s-1].lo_re << 1;
         nx.lo_im = st_ff[s-1].lo_im << 1;
         if (tr_re >= {1'b0, st_ff[s-1].den}) begin
            nx.r_re = PW'(tr_re - {1'b0, st_ff[s-1].den});
            nx.q_re = {st_ff[s-1].q_re[DW-2:0], 1'b1};
         end else begin
            nx.r_re = tr_re[PW-1:0];
            nx.q_re = {st_ff[s-1].q_re[DW-2:0], 1'b0};
         end
         if (tr_im >= {1'b0, st_ff[s-1].den}) begin
            nx.r_im = PW'(tr_im - {1'b0, st_ff[s-1].den});
            nx.q_im = {st_ff[s-1].q_im[DW-2:0], 1'b1};
         end else begin
            nx.r_im = tr_im[PW-1:0];
            nx.q_im = {st_ff[s-1].q_im[DW-2:0], 1'b0};
         end
         sq_t = st_ff[s-1].sq_r + SQ_BIT;
         if (st_ff[s-1].sq_v >= sq_t) begin
            nx.sq_v = st_ff[s-1].sq_v - sq_t;
            nx.sq_r = (st_ff[s-1].sq_r >> 1) + SQ_BIT;
         end else begin
            nx.sq_r = st_ff[s-1].sq_r >> 1;
         end
         xs = st_ff[s-1].x >>> (s - 1);
         ys = st_ff[s-1].y >>> (s - 1);
         if (s <= CS) begin
            if (st_ff[s-1].y > 0) begin
               nx.x = st_ff[s-1].x + ys;
               nx.y = st_ff[s-1].y - xs;
               nx.z = st_ff[s-1].z + AT;
            end else begin
               nx.x = st_ff[s-1].x - ys;
               nx.y = st_ff[s-1].y + xs;
               nx.z = st_ff[s-1].z - AT;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) v_ff[s] <= 1'b0;
         else if (en) v_ff[s] <= v_ff[s-1];
      end

      always_ff @(posedge clock) begin
         if (en) st_ff[s] <= nx;
      end
   end

   always_comb begin
      f_re    = '0;
      f_im    = '0;
      za      = (st_ff[DW].z + (64'sd1 <<< (ANG_SH - 1))) >>> ANG_SH;
      tail_in = st_ff[DW].done;
      unique case (st_ff[DW].cls)
         CLS_DIV: begin
            f_re = sat_mag(st_ff[DW].neg_re, st_ff[DW].q_re, st_ff[DW].big_re);
            f_im = sat_mag(st_ff[DW].neg_im, st_ff[DW].q_im, st_ff[DW].big_im);
         end
         CLS_SQRT: f_re = sat_mag(1'b0, st_ff[DW].sq_r[DW-1:0], |st_ff[DW].sq_r[PW-1:DW]);
         CLS_ARG:  f_re = sat_wide(za);
         default: begin
         end
      endcase
      if (st_ff[DW].cls != CLS_DONE) begin
         tail_in.res_re = f_re[DW-1:0];
         tail_in.res_im = f_im[DW-1:0];
         tail_in.status = (f_re[DW] || f_im[DW]) ? ST_SAT : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) tail_v_ff <= 1'b0;
      else if (en) tail_v_ff <= v_ff[DW];
   end

   always_ff @(posedge clock) begin
      if (en) tail_ff <= tail_in;
   end

endmodule

// ----- sv/complex_arithmetic_unit.sv -----
// Complex arithmetic unit: two-stage front end, work queue, pipelined back end
// Throughput: one word per cycle on every command while no full queue stalls it; nothing iterates in place.
// The back end holds a 32-step divider and square-root pipeline.
// Reset (synchronous, active high) empties both queues and clears stage valid bits;
// no clearing pass is needed.
module complex_arithmetic_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  cau_pkg::req_type req_data,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output cau_pkg::rsp_type rsp_data
);
   import cau_pkg::*;

   logic     wk_push, wk_full, wk_pop, wk_empty;
   work_type wk_in_data, wk_out_data;
   logic     out_push, out_full;
   rsp_type  out_data;

   cau_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .wk_push  (wk_push),
      .wk_data  (wk_in_data),
      .wk_full  (wk_full)
   );

   cau_queue #(
      .WIDTH ($bits(work_type)),
      .DEPTH (4)
   ) u_work_q (
      .clock     (clock),
      .reset     (reset),
      .push      (wk_push),
      .push_data (wk_in_data),
      .full      (wk_full),
      .pop       (wk_pop),
      .pop_data  (wk_out_data),
      .empty     (wk_empty)
   );

   cau_back u_back (
      .clock    (clock),
      .reset    (reset),
      .wk_empty (wk_empty),
      .wk_data  (wk_out_data),
      .wk_pop   (wk_pop),
      .out_push (out_push),
      .out_data (out_data),
      .out_full (out_full)
   );

   cau_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (2)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule
